/* design/chacha_pkg.sv */
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR - shared definitions
// Word and state types, block constants and register index codes.
// ----------------------------------------------------------------------------
package chacha_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] block_t;

  localparam word_t SIGMA0       = 32'h6170_7865;
  localparam word_t SIGMA1       = 32'h3320_646e;
  localparam word_t SIGMA2       = 32'h7962_2d32;
  localparam word_t SIGMA3       = 32'h6b20_6574;
  localparam word_t COUNTER_LAST = 32'hFFFF_FFFF;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_MD  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CTR_START = 4'd7;

  localparam logic [1:0] NONCE_8B  = 2'd0;
  localparam logic [1:0] NONCE_12B = 2'd1;

endpackage

/* design/chacha_core.sv */
// ----------------------------------------------------------------------------
// ChaCha20 block core
// Four quarter-round lanes run one add/xor/rotate step per cycle; 80 steps
// give the 20 rounds, then feed-forward adds the input state row by row.
// ----------------------------------------------------------------------------
module chacha_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  chacha_pkg::block_t   init_i,
  input  logic [3:0]           rd_idx_i,
  output chacha_pkg::word_t    rd_word_o,
  output logic                 done_o
);

  localparam logic [1:0] CORE_IDLE = 2'd0;
  localparam logic [1:0] CORE_RND  = 2'd1;
  localparam logic [1:0] CORE_FF   = 2'd2;

  localparam logic [6:0] LAST_STEP = 7'd79;

  logic [1:0]         state_q, state_d;
  logic [6:0]         cnt_q, cnt_d;
  chacha_pkg::block_t work_q, work_d;

  // step count: [1:0] quarter-round phase, [2] diagonal, [6:3] double round
  logic [1:0] phase;
  logic       diag;

  assign phase = cnt_q[1:0];
  assign diag  = cnt_q[2];

  always_comb begin
    logic [1:0]        kk;
    logic [3:0]        ia, ib, ic, id;
    chacha_pkg::word_t sum, x;
    work_d = work_q;
    for (int k = 0; k < 4; k++) begin
      kk = 2'(k);
      ia = {2'b00, kk};
      if (diag) begin
        ib = {2'b01, kk + 2'd1};
        ic = {2'b10, kk + 2'd2};
        id = {2'b11, kk + 2'd3};
      end else begin
        ib = {2'b01, kk};
        ic = {2'b10, kk};
        id = {2'b11, kk};
      end
      if (phase[0]) begin
        sum = work_q[ic] + work_q[id];
        x   = sum ^ work_q[ib];
      end else begin
        sum = work_q[ia] + work_q[ib];
        x   = sum ^ work_q[id];
      end
      if (state_q == CORE_RND) begin
        case (phase)
          2'd0: begin
            work_d[ia] = sum;
            work_d[id] = {x[15:0], x[31:16]};
          end
          2'd1: begin
            work_d[ic] = sum;
            work_d[ib] = {x[19:0], x[31:20]};
          end
          2'd2: begin
            work_d[ia] = sum;
            work_d[id] = {x[23:0], x[31:24]};
          end
          default: begin
            work_d[ic] = sum;
            work_d[ib] = {x[24:0], x[31:25]};
          end
        endcase
      end else if (state_q == CORE_FF) begin
        work_d[{phase, kk}] = work_q[{phase, kk}] + init_i[{phase, kk}];
      end
    end
    if (start_i) begin
      work_d = init_i;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      CORE_IDLE: begin
        if (start_i) begin
          state_d = CORE_RND;
          cnt_d   = '0;
        end
      end
      CORE_RND: begin
        if (cnt_q == LAST_STEP) begin
          state_d = CORE_FF;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      CORE_FF: begin
        if (phase == 2'd3) begin
          state_d = CORE_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      default: begin
        state_d = CORE_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign rd_word_o = work_q[rd_idx_i];
  assign done_o    = (state_q == CORE_FF) && (phase == 2'd3);

endmodule

/* design/chacha20_keystream_xor_top.sv */
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR - top level
// Byte-wide stream XOR with block counter, nonce modes and overflow flag.
// ----------------------------------------------------------------------------
// One byte per transfer. A byte inside the current 64-byte keystream block
// is accepted and its result registered in the cycle it is accepted, so 63
// of every 64 bytes run at one per cycle while the output is not stalled.
// The first byte of each block starts the block core: round steps on four
// shared quarter-round lanes, then the feed-forward add; its result is
// registered when the core is done, and no byte is taken meanwhile. When
// the counter is exhausted the byte passes unchanged with overflow set. Any
// configuration write to a valid index reloads the counter and restarts at
// byte 0 of a new block; write only while the block is idle.

module chacha20_keystream_xor_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                last_in_call_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          out_byte_o,
  output logic                                overflow_o,
  output logic                                last_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_GEN  = 1'b1;

  logic [63:0] key0_q, key1_q, key2_q, key3_q, nlo_q, nhi_q;
  logic [1:0]  mode_q;
  logic [31:0] cstart_q;

  logic                state_q;
  chacha_pkg::word_t   ctr_q;
  logic [5:0]          pos_q;
  logic [7:0]          data_q;
  logic                last_q;
  logic                out_valid_q, ovf_q, olast_q;
  logic [7:0]          obyte_q;

  chacha_pkg::block_t  init_blk;
  chacha_pkg::word_t   rd_word;
  logic                core_done;
  logic [7:0]          ks_byte;

  logic                cfg_hit;
  logic [63:0]         nlo_new;
  logic [1:0]          mode_new;
  logic [31:0]         cstart_new;

  logic need_blk, exhausted, out_free, in_acc, start;

  // ---- configuration ----
  always_comb begin
    cfg_hit    = 1'b0;
    nlo_new    = nlo_q;
    mode_new   = mode_q;
    cstart_new = cstart_q;
    unique case (cfg_idx_i)
      chacha_pkg::CFG_KEY0, chacha_pkg::CFG_KEY1, chacha_pkg::CFG_KEY2,
      chacha_pkg::CFG_KEY3, chacha_pkg::CFG_NONCE_HI: cfg_hit = 1'b1;
      chacha_pkg::CFG_NONCE_LO: begin
        cfg_hit = 1'b1;
        nlo_new = cfg_wdata_i;
      end
      chacha_pkg::CFG_NONCE_MD: begin
        cfg_hit  = 1'b1;
        mode_new = cfg_wdata_i[1:0];
      end
      chacha_pkg::CFG_CTR_START: begin
        cfg_hit    = 1'b1;
        cstart_new = cfg_wdata_i[31:0];
      end
      default: cfg_hit = 1'b0;
    endcase
    cfg_hit = cfg_hit & cfg_we_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q   <= '0;
      key1_q   <= '0;
      key2_q   <= '0;
      key3_q   <= '0;
      nlo_q    <= '0;
      nhi_q    <= '0;
      mode_q   <= chacha_pkg::NONCE_12B;
      cstart_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == chacha_pkg::CFG_KEY0) key0_q <= cfg_wdata_i;
      if (cfg_idx_i == chacha_pkg::CFG_KEY1) key1_q <= cfg_wdata_i;
      if (cfg_idx_i == chacha_pkg::CFG_KEY2) key2_q <= cfg_wdata_i;
      if (cfg_idx_i == chacha_pkg::CFG_KEY3) key3_q <= cfg_wdata_i;
      if (cfg_idx_i == chacha_pkg::CFG_NONCE_HI) nhi_q <= cfg_wdata_i;
      nlo_q    <= nlo_new;
      mode_q   <= mode_new;
      cstart_q <= cstart_new;
    end
  end

  // ---- block input state ----
  always_comb begin
    init_blk[0]  = chacha_pkg::SIGMA0;
    init_blk[1]  = chacha_pkg::SIGMA1;
    init_blk[2]  = chacha_pkg::SIGMA2;
    init_blk[3]  = chacha_pkg::SIGMA3;
    init_blk[4]  = key0_q[31:0];
    init_blk[5]  = key0_q[63:32];
    init_blk[6]  = key1_q[31:0];
    init_blk[7]  = key1_q[63:32];
    init_blk[8]  = key2_q[31:0];
    init_blk[9]  = key2_q[63:32];
    init_blk[10] = key3_q[31:0];
    init_blk[11] = key3_q[63:32];
    init_blk[12] = ctr_q;
    if (mode_q == chacha_pkg::NONCE_8B) begin
      init_blk[13] = '0;
      init_blk[14] = nlo_q[31:0];
      init_blk[15] = nlo_q[63:32];
    end else if (mode_q == chacha_pkg::NONCE_12B) begin
      init_blk[13] = nlo_q[31:0];
      init_blk[14] = nlo_q[63:32];
      init_blk[15] = nhi_q[31:0];
    end else begin
      init_blk[13] = nlo_q[63:32];
      init_blk[14] = nhi_q[31:0];
      init_blk[15] = nhi_q[63:32];
    end
  end

  chacha_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .init_i    (init_blk),
    .rd_idx_i  (pos_q[5:2]),
    .rd_word_o (rd_word),
    .done_o    (core_done)
  );

  assign ks_byte = rd_word[{pos_q[1:0], 3'b000} +: 8];

  // ---- handshake ----
  assign need_blk   = (pos_q == 6'd0);
  assign exhausted  = (ctr_q == chacha_pkg::COUNTER_LAST);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && need_blk && !exhausted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ctr_q   <= '0;
      pos_q   <= '0;
    end else if (cfg_hit) begin
      ctr_q <= (mode_new[1]) ? nlo_new[31:0] : cstart_new;
      pos_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_GEN;
          end else if (in_acc && !need_blk) begin
            pos_q <= pos_q + 6'd1;
          end
        end
        ST_GEN: begin
          if (core_done) begin
            state_q <= ST_IDLE;
            ctr_q   <= ctr_q + 32'd1;
            pos_q   <= 6'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      data_q <= data_byte_i;
      last_q <= last_in_call_i;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_acc && !start) || (state_q == ST_GEN && core_done)) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !start) begin
      // overflow only reaches this path at byte 0 with the counter spent
      obyte_q <= need_blk ? data_byte_i : (data_byte_i ^ ks_byte);
      ovf_q   <= need_blk;
      olast_q <= last_in_call_i;
    end else if (state_q == ST_GEN && core_done) begin
      obyte_q <= data_q ^ ks_byte;
      ovf_q   <= 1'b0;
      olast_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = obyte_q;
  assign overflow_o  = ovf_q;
  assign last_o      = olast_q;

endmodule
